FILE: rtl/core/ffca_pkg.sv
// Shared types, codes and defaults for the first-fit coalescing allocator.
package ffca_pkg;

  localparam int MaxExtentsDef  = 64;
  localparam int AddrBitsDef    = 20;
  localparam int HeaderBytesDef = 8;
  localparam int NodeBytesDef   = 16;
  localparam int WordBytesDef   = 8;   // power of two
  localparam int FieldW         = 21;
  localparam int WideW          = 22;
  localparam logic [FieldW-1:0] ArenaReset = 21'd65536;
  localparam logic [FieldW-1:0] ArenaCap   = 21'd1048576;
  localparam logic [FieldW-1:0] ArenaMin   = 21'd16;

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } ffca_func_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_OOB   = 2'd2,
    ST_FULL  = 2'd3
  } ffca_status_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [FieldW-1:0] req_size;
    logic [FieldW-1:0] address;
    logic [FieldW-1:0] block_size;
  } ffca_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FieldW-1:0] alloc_address;
    logic [FieldW-1:0] granted_size;
    logic [FieldW-1:0] free_bytes;
  } ffca_rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_SET_ST, OP_RD_IDX, OP_EVAL, OP_FREE_END,
    OP_FREE_AT, OP_SPLIT, OP_GRANT_WHOLE, OP_JOIN_BOTH, OP_JOIN_PREV,
    OP_JOIN_NEXT, OP_INS_INIT, OP_INS_RD, OP_INS_WR, OP_RM_RD, OP_RM_WR,
    OP_RM_END, OP_WR_NEW, OP_OUT
  } ffca_op_t;

  typedef struct packed {
    ffca_op_t     op;
    ffca_status_t code;
  } ffca_cmd_t;

  typedef struct packed {
    ffca_func_e_t func;
    logic         bad;        // free outside arena
    logic         zero;       // free of empty block
    logic         scan_end;
    logic         ev_stop;    // alloc fits, or free position found
    logic         small_rest;
    logic         ovl;
    logic         join_prev;
    logic         join_next;
    logic         full;
    logic         rm_more;
    logic         ins_more;
    logic         out_busy;
  } ffca_flags_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_EV, S_FREE_DEC, S_RM_CHK, S_RM_WR,
    S_INS_CHK, S_INS_WR, S_DONE
  } ffca_state_t;

endpackage

FILE: rtl/core/first_fit_coalescing_allocator_top.sv
// Top level of the first-fit coalescing allocator.
//
//   channel   signals                        word
//   request   req_valid / req_stall / req    func, req_size, address, block_size
//   response  rsp_valid / rsp_stall / rsp    status, alloc_address, granted_size, free_bytes
//   config    cfg_we / cfg_data              arena_bytes
//
// One word at a time. Each word is loaded and dispatched, then the extent table is scanned
// entry by entry (read, then evaluate) until a fit or the free position is found or the scan
// runs off the end; a scanned free then takes a merge decision, and removing or inserting
// an extent moves the entries behind it one by one through the table.
// Reset and config writes restore one whole-arena extent at once, no sweep.
// A stalled response holds its result; the next request is taken, its response waits behind.
module first_fit_coalescing_allocator_top import ffca_pkg::*; #(
  parameter int MAX_EXTENTS  = MaxExtentsDef,
  parameter int ADDR_BITS    = AddrBitsDef,
  parameter int HEADER_BYTES = HeaderBytesDef,
  parameter int NODE_BYTES   = NodeBytesDef,
  parameter int WORD_BYTES   = WordBytesDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ffca_req_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ffca_rsp_t         rsp,
  input  logic              cfg_we,
  input  logic [FieldW-1:0] cfg_data
);

  ffca_cmd_t   cmd;
  ffca_flags_t flags;
  logic        idle;

  assign req_stall = !idle || rst;

  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .flags     (flags),
    .cmd       (cmd),
    .idle      (idle)
  );

  ffca_dp #(
    .MAX_EXTENTS  (MAX_EXTENTS),
    .ADDR_BITS    (ADDR_BITS),
    .HEADER_BYTES (HEADER_BYTES),
    .NODE_BYTES   (NODE_BYTES),
    .WORD_BYTES   (WORD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .flags     (flags),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/core/ffca_dp.sv
// Datapath: extent table memory, scan registers, totals and result word.
module ffca_dp import ffca_pkg::*; #(
  parameter int MAX_EXTENTS  = MaxExtentsDef,
  parameter int ADDR_BITS    = AddrBitsDef,
  parameter int HEADER_BYTES = HeaderBytesDef,
  parameter int NODE_BYTES   = NodeBytesDef,
  parameter int WORD_BYTES   = WordBytesDef
) (
  input  logic              clk,
  input  logic              rst,
  input  ffca_req_t         req,
  input  logic              cfg_we,
  input  logic [FieldW-1:0] cfg_data,
  input  ffca_cmd_t         cmd,
  input  logic              rsp_stall,
  output ffca_flags_t       flags,
  output logic              rsp_valid,
  output ffca_rsp_t         rsp
);

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int EW = ADDR_BITS + FieldW;
  localparam longint LimWide = (64'd1 << ADDR_BITS);
  localparam logic [FieldW-1:0] ArenaLim =
    (LimWide < 64'(ArenaCap)) ? FieldW'(LimWide) : ArenaCap;
  localparam logic [FieldW-1:0] WordMask = ~FieldW'(WORD_BYTES - 1);
  localparam logic [FieldW-1:0] ArenaInit =
    ((ArenaReset > ArenaLim) ? ArenaLim : ArenaReset) & WordMask;
  localparam logic [WideW-1:0] WordMaskW = ~WideW'(WORD_BYTES - 1);

  logic [EW-1:0] mem [MAX_EXTENTS];
  logic [EW-1:0] rd_q;
  logic          rd_fresh;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;

  ffca_func_e_t      func;
  logic [WideW-1:0]  need, start, endv;
  logic [FieldW-1:0] size, addr_in;
  logic [CW-1:0]     idx, pos, count;
  logic [WideW-1:0]  prev_base, next_base;
  logic [FieldW-1:0] prev_len, next_len;
  logic              have_prev, have_next;
  logic [FieldW-1:0] free_total, arena;
  logic              fresh;
  ffca_status_t      res_status;
  logic [FieldW-1:0] res_addr, res_granted;

  logic [WideW-1:0]  ent_base, rest, prev_end, need_in, pad;
  logic [FieldW-1:0] ent_len, cfg_clamp;

  // entry 0 reads as the whole arena until it is written
  always_comb begin
    ent_base = rd_fresh ? '0 : WideW'(rd_q[EW-1:FieldW]);
    ent_len  = rd_fresh ? arena : rd_q[FieldW-1:0];
    rest     = WideW'(ent_len) - need;
    prev_end = prev_base + WideW'(prev_len);
    pad      = (WideW'(req.req_size) + WideW'(HEADER_BYTES) + WideW'(WORD_BYTES - 1))
               & WordMaskW;
    need_in  = (pad < WideW'(NODE_BYTES)) ? WideW'(NODE_BYTES) : pad;
    if (cfg_data < ArenaMin) begin
      cfg_clamp = ArenaMin;
    end else if (cfg_data > ArenaLim) begin
      cfg_clamp = ArenaLim;
    end else begin
      cfg_clamp = cfg_data;
    end
    cfg_clamp = cfg_clamp & WordMask;
  end

  always_comb begin
    flags.func       = func;
    flags.bad        = (addr_in < FieldW'(HEADER_BYTES)) || (endv > WideW'(arena));
    flags.zero       = (size == '0);
    flags.scan_end   = (idx >= count);
    flags.ev_stop    = (func == FN_ALLOC) ? (WideW'(ent_len) >= need) : !(ent_base < start);
    flags.small_rest = (rest < WideW'(NODE_BYTES));
    flags.ovl        = (have_prev && prev_end > start) || (have_next && endv > next_base);
    flags.join_prev  = have_prev && (prev_end == start);
    flags.join_next  = have_next && (endv == next_base);
    flags.full       = (count >= CW'(MAX_EXTENTS));
    flags.rm_more    = ((idx + CW'(1)) < count);
    flags.ins_more   = (idx > pos);
    flags.out_busy   = rsp_valid && rsp_stall;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = {ADDR_BITS'(ent_base), ent_len};
    case (cmd.op)
      OP_RD_IDX: rd_en = 1'b1;
      OP_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx[AW-1:0] + AW'(1);
      end
      OP_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx[AW-1:0] - AW'(1);
      end
      OP_SPLIT: begin
        wr_en   = 1'b1;
        wr_data = {ADDR_BITS'(ent_base + need), FieldW'(rest)};
      end
      OP_JOIN_BOTH: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0] - AW'(1);
        wr_data = {ADDR_BITS'(prev_base), prev_len + size + next_len};
      end
      OP_JOIN_PREV: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0] - AW'(1);
        wr_data = {ADDR_BITS'(prev_base), prev_len + size};
      end
      OP_JOIN_NEXT: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0];
        wr_data = {ADDR_BITS'(start), next_len + size};
      end
      OP_WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = pos[AW-1:0];
        wr_data = {ADDR_BITS'(start), size};
      end
      OP_INS_WR, OP_RM_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_fresh <= fresh && (rd_addr == '0);
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        func        <= ffca_func_e_t'(req.func);
        need        <= need_in;
        addr_in     <= req.address;
        start       <= WideW'(req.address) - WideW'(HEADER_BYTES);
        endv        <= WideW'(req.address) - WideW'(HEADER_BYTES) + WideW'(req.block_size);
        size        <= req.block_size;
        idx         <= '0;
        have_prev   <= 1'b0;
        have_next   <= 1'b0;
        res_status  <= ST_OK;
        res_addr    <= '0;
        res_granted <= '0;
      end
      OP_SET_ST: res_status <= cmd.code;
      OP_EVAL: begin
        if (func == FN_FREE) begin
          prev_base <= ent_base;
          prev_len  <= ent_len;
          have_prev <= 1'b1;
        end
        idx <= idx + CW'(1);
      end
      OP_FREE_END: pos <= idx;
      OP_FREE_AT: begin
        pos       <= idx;
        next_base <= ent_base;
        next_len  <= ent_len;
        have_next <= 1'b1;
      end
      OP_SPLIT: begin
        res_addr    <= FieldW'(ent_base + WideW'(HEADER_BYTES));
        res_granted <= FieldW'(need);
      end
      OP_GRANT_WHOLE: begin
        res_addr    <= FieldW'(ent_base + WideW'(HEADER_BYTES));
        res_granted <= ent_len;
      end
      OP_JOIN_BOTH: idx <= pos;
      OP_INS_INIT:  idx <= count;
      OP_INS_WR:    idx <= idx - CW'(1);
      OP_RM_WR:     idx <= idx + CW'(1);
      default: ;
    endcase
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      arena      <= ArenaInit;
      free_total <= ArenaInit;
      count      <= CW'(1);
      fresh      <= 1'b1;
    end else if (cfg_we) begin
      arena      <= cfg_clamp;
      free_total <= cfg_clamp;
      count      <= CW'(1);
      fresh      <= 1'b1;
    end else begin
      if (wr_en && wr_addr == '0) begin
        fresh <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: begin
          free_total <= arena;
          count      <= CW'(1);
          fresh      <= 1'b1;
        end
        OP_SPLIT:       free_total <= free_total - FieldW'(need);
        OP_GRANT_WHOLE: free_total <= free_total - ent_len;
        OP_JOIN_BOTH, OP_JOIN_PREV, OP_JOIN_NEXT: free_total <= free_total + size;
        OP_WR_NEW: begin
          free_total <= free_total + size;
          count      <= count + CW'(1);
        end
        OP_RM_END: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      rsp.status        <= res_status;
      rsp.alloc_address <= res_addr;
      rsp.granted_size  <= res_granted;
      rsp.free_bytes    <= free_total;
    end
  end

endmodule

FILE: rtl/core/ffca_ctrl.sv
// Controller: sequences scan, split, merge and table shifts.
module ffca_ctrl import ffca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  ffca_flags_t flags,
  output ffca_cmd_t   cmd,
  output logic        idle
);

  ffca_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    idle       = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (flags.func)
          FN_ALLOC: state_next = S_SCAN_RD;
          FN_FREE: begin
            if (flags.bad) begin
              cmd.op     = OP_SET_ST;
              cmd.code   = ST_OOB;
              state_next = S_DONE;
            end else if (flags.zero) begin
              state_next = S_DONE;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          FN_CLEAR: begin
            cmd.op     = OP_CLEAR;
            state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN_RD: begin
        if (!flags.scan_end) begin
          cmd.op     = OP_RD_IDX;
          state_next = S_SCAN_EV;
        end else if (flags.func == FN_ALLOC) begin
          cmd.op     = OP_SET_ST;
          cmd.code   = ST_NOFIT;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_FREE_END;
          state_next = S_FREE_DEC;
        end
      end
      S_SCAN_EV: begin
        if (!flags.ev_stop) begin
          cmd.op     = OP_EVAL;
          state_next = S_SCAN_RD;
        end else if (flags.func == FN_FREE) begin
          cmd.op     = OP_FREE_AT;
          state_next = S_FREE_DEC;
        end else if (flags.small_rest) begin
          cmd.op     = OP_GRANT_WHOLE;
          state_next = S_RM_CHK;
        end else begin
          cmd.op     = OP_SPLIT;
          state_next = S_DONE;
        end
      end
      S_FREE_DEC: begin
        if (flags.ovl) begin
          cmd.op     = OP_SET_ST;
          cmd.code   = ST_OOB;
          state_next = S_DONE;
        end else if (flags.join_prev && flags.join_next) begin
          cmd.op     = OP_JOIN_BOTH;
          state_next = S_RM_CHK;
        end else if (flags.join_prev) begin
          cmd.op     = OP_JOIN_PREV;
          state_next = S_DONE;
        end else if (flags.join_next) begin
          cmd.op     = OP_JOIN_NEXT;
          state_next = S_DONE;
        end else if (flags.full) begin
          cmd.op     = OP_SET_ST;
          cmd.code   = ST_FULL;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_INS_INIT;
          state_next = S_INS_CHK;
        end
      end
      // close the gap left by a removed extent, one entry per pass
      S_RM_CHK: begin
        if (flags.rm_more) begin
          cmd.op     = OP_RM_RD;
          state_next = S_RM_WR;
        end else begin
          cmd.op     = OP_RM_END;
          state_next = S_DONE;
        end
      end
      S_RM_WR: begin
        cmd.op     = OP_RM_WR;
        state_next = S_RM_CHK;
      end
      // open a slot at the insert position, walking down from the top
      S_INS_CHK: begin
        if (flags.ins_more) begin
          cmd.op     = OP_INS_RD;
          state_next = S_INS_WR;
        end else begin
          cmd.op     = OP_WR_NEW;
          state_next = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd.op     = OP_INS_WR;
        state_next = S_INS_CHK;
      end
      S_DONE: begin
        if (!flags.out_busy) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
